@@ sv/vne_pkg.sv @@
// ----------------------------------------------------------------------------
// vne_pkg
// Shared types and constants for the vector norm engine.
// ----------------------------------------------------------------------------
package vne_pkg;

  localparam int ELEM_W             = 16;
  localparam int SUM_W              = 56;
  localparam int OUT_W              = 41;
  localparam int TERM_W             = 48;
  localparam int ROOT_W             = 28;
  localparam int R2_W               = 40;
  localparam int REM_W              = 48;
  localparam int STEP_W             = 5;
  localparam int SQRT_STEPS         = 28;
  localparam int CBRT_STEPS         = 19;
  localparam int ELEMENT_WIDTH_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF    = 4;

  localparam logic [OUT_W-1:0] OUT_MAX = OUT_W'(1) << (OUT_W - 1);

  typedef enum logic [1:0] {
    MODE_L1   = 2'd0,
    MODE_L2SQ = 2'd1,
    MODE_L2   = 2'd2,
    MODE_L3   = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] norm_value;
    logic             saturated;
  } out_item_t;

  // Finished vector sum handed from the front to the back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             ovf;
    mode_t            mode;
  } acc_entry_t;

  typedef struct packed {
    logic             start;
    logic             cube;
    logic [SUM_W-1:0] value;
  } root_req_t;

  typedef enum logic {
    B_IDLE,
    B_ROOT
  } back_state_t;

endpackage

@@ sv/vne_front.sv @@
// ----------------------------------------------------------------------------
// vne_front
// Element intake: magnitude, power term pipeline and saturating accumulator.
// ----------------------------------------------------------------------------
module vne_front import vne_pkg::*; #(
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  in_item_t         in_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_data,
  input  logic [CNT_W-1:0] q_count,
  output logic             q_push,
  output acc_entry_t       q_entry
);

  localparam int OCC_W = CNT_W + 2;

  mode_t mode_r;

  logic                     accept;
  logic [ELEMENT_WIDTH-1:0] raw;
  logic [ELEMENT_WIDTH-1:0] mag_n;

  logic              s1_vld_r, s1_last_r;
  mode_t             s1_mode_r;
  logic [ELEM_W-1:0] s1_mag_r;

  logic              s2_vld_r, s2_last_r;
  mode_t             s2_mode_r;
  logic [ELEM_W-1:0] s2_mag_r;
  logic [31:0]       s2_sq_r;

  logic              s3_vld_r, s3_last_r;
  mode_t             s3_mode_r;
  logic [TERM_W-1:0] s3_term_r;

  logic [31:0]       sq_w;
  logic [TERM_W-1:0] cube_w;
  logic [TERM_W-1:0] term_w;

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             ovf_r, ovf_nxt;
  logic [SUM_W:0]   acc_w;
  logic [1:0]       n_last;

  assign raw    = in_data.element[ELEMENT_WIDTH-1:0];
  assign mag_n  = raw[ELEMENT_WIDTH-1] ? (~raw + 1'b1) : raw;
  assign accept = in_push & ~in_full;

  // Reserve a queue slot for every vector end still in the pipeline
  assign n_last  = 2'(s1_vld_r & s1_last_r) + 2'(s2_vld_r & s2_last_r)
                 + 2'(s3_vld_r & s3_last_r);
  assign in_full = (OCC_W'(q_count) + OCC_W'(n_last)) >= OCC_W'(QUEUE_DEPTH);

  assign sq_w   = 32'(s1_mag_r) * 32'(s1_mag_r);
  assign cube_w = TERM_W'(s2_sq_r) * TERM_W'(s2_mag_r);

  always_comb begin
    case (s2_mode_r)
      MODE_L1: term_w = TERM_W'(s2_mag_r);
      MODE_L3: term_w = cube_w;
      default: term_w = TERM_W'(s2_sq_r);
    endcase
  end

  assign acc_w   = {1'b0, sum_r} + (SUM_W + 1)'(s3_term_r);
  assign sum_nxt = acc_w[SUM_W] ? {SUM_W{1'b1}} : acc_w[SUM_W-1:0];
  assign ovf_nxt = ovf_r | acc_w[SUM_W];

  assign q_push  = s3_vld_r & s3_last_r;
  assign q_entry = acc_entry_t'{sum: sum_nxt, ovf: ovf_nxt, mode: s3_mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_L1;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      sum_r    <= '0;
      ovf_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= mode_t'(cfg_data);
      end
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      if (s3_vld_r) begin
        // drop the sum once the vector end has been handed over
        if (s3_last_r) begin
          sum_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          sum_r <= sum_nxt;
          ovf_r <= ovf_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= in_data.last;
    s1_mode_r <= mode_r;
    s1_mag_r  <= ELEM_W'(mag_n);
    s2_last_r <= s1_last_r;
    s2_mode_r <= s1_mode_r;
    s2_mag_r  <= s1_mag_r;
    s2_sq_r   <= sq_w;
    s3_last_r <= s2_last_r;
    s3_mode_r <= s2_mode_r;
    s3_term_r <= term_w;
  end

endmodule

@@ sv/vne_queue.sv @@
// ----------------------------------------------------------------------------
// vne_queue
// Short queue of finished vector sums between front and back.
// ----------------------------------------------------------------------------
module vne_queue import vne_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int PTR_W      = $clog2(QUEUE_DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  acc_entry_t       entry_in,
  input  logic             pop,
  output acc_entry_t       head,
  output logic             empty,
  output logic [CNT_W-1:0] count
);

  acc_entry_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign empty  = (count_r == '0);
  assign count  = count_r;
  assign head   = slot_r[rd_ptr_r];
  assign do_pop = pop & ~empty;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ sv/vne_root.sv @@
// ----------------------------------------------------------------------------
// vne_root
// Iterative floored square / cube root, one root bit per cycle.
// ----------------------------------------------------------------------------
module vne_root import vne_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  root_req_t         req,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [STEP_W-1:0] cnt_r;
  logic              cube_r;
  logic [SUM_W:0]    sh_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] r_r;
  logic [R2_W-1:0]   r2_r;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // Bring down the next digit group of the radicand
  assign rem_sh = cube_r ? {rem_r[REM_W-4:0], sh_r[SUM_W:SUM_W-2]}
                         : {rem_r[REM_W-3:0], sh_r[SUM_W:SUM_W-1]};

  // Cube: (2r+1)^3 - (2r)^3 = 12r^2 + 6r + 1. Square: 4r + 1.
  assign trial = cube_r
    ? (REM_W'({r2_r, 3'b000}) + REM_W'({r2_r, 2'b00}) + REM_W'({r_r, 2'b00})
       + REM_W'({r_r, 1'b0}) + REM_W'(1))
    : REM_W'({r_r, 2'b01});

  assign fits = rem_sh >= trial;
  assign done = (cnt_r == '0);
  assign root = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= req.cube ? STEP_W'(CBRT_STEPS) : STEP_W'(SQRT_STEPS);
    end else if (!done) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cube_r <= req.cube;
      sh_r   <= req.cube ? {1'b0, req.value} : {req.value, 1'b0};
      rem_r  <= '0;
      r_r    <= '0;
      r2_r   <= '0;
    end else if (!done) begin
      sh_r <= cube_r ? {sh_r[SUM_W-3:0], 3'b000} : {sh_r[SUM_W-2:0], 2'b00};
      if (fits) begin
        rem_r <= rem_sh - trial;
        r_r   <= {r_r[ROOT_W-2:0], 1'b1};
        r2_r  <= {r2_r[R2_W-3:0], 2'b00} + R2_W'({r_r, 2'b00}) + R2_W'(1);
      end else begin
        rem_r <= rem_sh;
        r_r   <= {r_r[ROOT_W-2:0], 1'b0};
        r2_r  <= {r2_r[R2_W-3:0], 2'b00};
      end
    end
  end

endmodule

@@ sv/vne_back.sv @@
// ----------------------------------------------------------------------------
// vne_back
// Result stage: takes finished sums, runs roots, clamps and holds the result.
// ----------------------------------------------------------------------------
module vne_back import vne_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  acc_entry_t q_head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output out_item_t  out_data
);

  back_state_t state_r, state_nxt;
  logic        ovf_r, ovf_nxt;
  logic        out_vld_r, out_vld_nxt;
  out_item_t   out_data_r;

  root_req_t         req;
  logic              root_done;
  logic [ROOT_W-1:0] root;

  logic             ob_free;
  logic             is_root;
  logic             over;
  logic [OUT_W-1:0] direct_val;
  logic             ld;
  out_item_t        ld_data;

  vne_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .done  (root_done),
    .root  (root)
  );

  assign ob_free    = ~out_vld_r | out_pop;
  assign is_root    = (q_head.mode == MODE_L2) || (q_head.mode == MODE_L3);
  assign over       = q_head.sum > SUM_W'(OUT_MAX);
  assign direct_val = over ? OUT_MAX : q_head.sum[OUT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    ovf_nxt   = ovf_r;
    q_pop     = 1'b0;
    ld        = 1'b0;
    ld_data   = out_item_t'{norm_value: direct_val, saturated: q_head.ovf | over};
    req       = root_req_t'{start: 1'b0, cube: q_head.mode == MODE_L3,
                            value: q_head.sum};
    case (state_r)
      B_IDLE: begin
        if (!q_empty && ob_free) begin
          q_pop = 1'b1;
          if (is_root) begin
            req.start = 1'b1;
            ovf_nxt   = q_head.ovf;
            state_nxt = B_ROOT;
          end else begin
            ld = 1'b1;
          end
        end
      end
      B_ROOT: begin
        // hold the finished root until the output register frees up
        if (root_done && ob_free) begin
          ld        = 1'b1;
          ld_data   = out_item_t'{norm_value: OUT_W'(root), saturated: ovf_r};
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign out_vld_nxt = ld | (out_vld_r & ~out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r <= ovf_nxt;
    if (ld) begin
      out_data_r <= ld_data;
    end
  end

  assign out_empty = ~out_vld_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/vector_norm_engine.sv @@
// ----------------------------------------------------------------------------
// vector_norm_engine
// Streaming L1 / L2 squared / L2 / L3 norm of signed Q8.8 vectors.
// ----------------------------------------------------------------------------
//   Channel  Direction  Ports                     Contents
//   in       queue in   in_push, in_full, in_data element, last
//   out      queue out  out_pop, out_empty,       norm_value, saturated
//                       out_data
//   cfg      write      cfg_we, cfg_data          norm_mode
//
// One element is taken per cycle while in_full is low; each element passes the
// term pipeline registers s1, s2 and s3 and the accumulator on its way to the end-of-vector queue.
// L1 and L2 squared results are loaded into the output register from the queue
// head; L2 and L3 results first pass through the shared root unit, and the
// finished root is held until the output register is free.
// in_full rises when the queue, counting vector ends still in the pipeline,
// has no free slot; a stalled output holds the back end and then the queue.
// Reset (rst_n low at a clock edge) empties the pipeline, queue and output and
// sets norm_mode to L1.
// ----------------------------------------------------------------------------
module vector_norm_engine import vne_pkg::*; #(
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  in_item_t   in_data,
  output logic       out_empty,
  input  logic       out_pop,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             q_push;
  acc_entry_t       q_entry;
  logic             q_pop;
  acc_entry_t       q_head;
  logic             q_empty;
  logic [CNT_W-1:0] q_count;

  vne_front #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  vne_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .entry_in (q_entry),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .count    (q_count)
  );

  vne_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

@@ sv/vne_checker.sv @@
// ----------------------------------------------------------------------------
// vne_checker
// Port-level checks for the vector norm engine, bound to the top level.
// ----------------------------------------------------------------------------
module vne_checker import vne_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_push,
  input logic       in_full,
  input in_item_t   in_data,
  input logic       out_empty,
  input logic       out_pop,
  input out_item_t  out_data,
  input logic       cfg_we,
  input logic [1:0] cfg_data
);

  // Reset drops every pending result
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  // Reset leaves room for new elements
  a_reset_room : assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // Clamp keeps every result at or below 2^40
  a_clamp : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.norm_value <= OUT_MAX))
    else $error("norm_value above clamp");

  // A waiting result holds until taken
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("result changed while waiting");

endmodule

bind vector_norm_engine vne_checker u_vne_checker (.*);

@@ tb/sv/norm_checker.sv @@
// ----------------------------------------------------------------------------
// norm_checker
// Watches the element, result and mode channels of the vector norm engine,
// predicts each norm from the accepted elements and compares it field by
// field with the result popped from the engine.
// ----------------------------------------------------------------------------
module norm_checker import vne_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  logic      in_full,
  input  in_item_t  in_data,
  input  logic      out_empty,
  input  logic      out_pop,
  input  out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_data,
  output int        mismatches,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;

  mode_t       cur_mode;
  logic [63:0] norm_sum;
  logic        sum_clipped;
  out_item_t   expected_norms[$];
  out_item_t   want;
  logic [63:0] mag;
  logic [63:0] term;
  logic [63:0] norm;
  logic        sat;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = SQRT_STEPS - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  // the sum is below 2^56, so every trial root is below 2^19 and its cube fits
  function automatic logic [63:0] floor_cbrt(input logic [63:0] s);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = CBRT_STEPS - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t * t <= s) r = t;
    end
    return r;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_mode    = MODE_L1;
      norm_sum    = '0;
      sum_clipped = 1'b0;
      expected_norms.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_norms.size() == 0) begin
          $display("%0t: unexpected result, expected none, got norm_value %0d saturated %0b",
                   $time, out_data.norm_value, out_data.saturated);
          mismatches++;
        end else begin
          want = expected_norms.pop_front();
          if (out_data.norm_value !== want.norm_value) begin
            $display("%0t: norm_value mismatch, expected %0d, got %0d",
                     $time, want.norm_value, out_data.norm_value);
            mismatches++;
          end
          if (out_data.saturated !== want.saturated) begin
            $display("%0t: saturated mismatch, expected %0b, got %0b",
                     $time, want.saturated, out_data.saturated);
            mismatches++;
          end
        end
      end

      if (in_push && !in_full) begin
        // magnitude of the most negative element is 2^15
        if (in_data.element[ELEM_W-1])
          mag = (64'd1 << ELEM_W) - {48'd0, in_data.element};
        else
          mag = {48'd0, in_data.element};
        case (cur_mode)
          MODE_L1: term = mag;
          MODE_L3: term = mag * mag * mag;
          default: term = mag * mag;
        endcase
        norm_sum = norm_sum + term;
        if (norm_sum > SUM_LIMIT) begin
          norm_sum    = SUM_LIMIT;
          sum_clipped = 1'b1;
        end
        if (in_data.last) begin
          case (cur_mode)
            MODE_L2: norm = floor_sqrt(norm_sum);
            MODE_L3: norm = floor_cbrt(norm_sum);
            default: norm = norm_sum;
          endcase
          sat = sum_clipped;
          if (norm > {23'd0, OUT_MAX}) begin
            norm = {23'd0, OUT_MAX};
            sat  = 1'b1;
          end
          want.norm_value = norm[OUT_W-1:0];
          want.saturated  = sat;
          expected_norms.push_back(want);
          norm_sum    = '0;
          sum_clipped = 1'b0;
        end
      end

      // a mode written at this edge applies from the next element on
      if (cfg_we) cur_mode = mode_t'(cfg_data);
    end
    outstanding = expected_norms.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives vectors of Q8.8 elements into the vector norm engine in all four
// norm modes, with random gaps and output stalls, and reports the verdict
// from the failure count of the norm checker.
// ----------------------------------------------------------------------------
module testbench;
  import vne_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 100;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_push   = 1'b0;
  logic       in_full;
  in_item_t   in_data   = '0;
  logic       out_empty;
  logic       out_pop   = 1'b0;
  out_item_t  out_data;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_data  = MODE_L1;
  int         mismatches;
  int         outstanding;
  bit         in_burst  = 1'b0;
  bit         out_burst = 1'b0;

  vector_norm_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  norm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly random gaps, with stretches of back-to-back traffic
  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [15:0] rand_element();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // enter and leave at a falling edge; push stays high for the next item
  task automatic push_element(input logic [15:0] elem, input logic last);
    int gap;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push         <= 1'b1;
    in_data.element <= elem;
    in_data.last    <= last;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  // wait for every result and for the pipeline to settle, then write the mode
  task automatic set_mode(input mode_t mode);
    in_push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // result side: pop with random stalls
  initial begin
    int stall;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = draw_gap(out_burst);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int len;
    int sent;
    mode_t mode;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes, zero and a short mixed vector in every mode
    for (int m = 0; m < 4; m++) begin
      set_mode(mode_t'(m));
      push_element(16'h7fff, 1'b1);
      push_element(16'h8000, 1'b1);
      push_element(16'h0000, 1'b1);
      push_element(16'h0001, 1'b0);
      push_element(16'hffff, 1'b0);
      push_element(16'h0100, 1'b1);
    end

    // change mode in the middle of a vector
    push_element(16'h8000, 1'b0);
    set_mode(MODE_L2);
    push_element(16'd12345, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mode = (p < 4) ? mode_t'(p) : mode_t'($urandom_range(0, 3));
      set_mode(mode);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) push_element(rand_element(), i == len - 1);
        sent += len;
      end
      // carry a partial vector across the next mode change
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) push_element(rand_element(), 1'b0);
    end
    push_element(rand_element(), 1'b1);

    in_push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
